FILE: sv/sts_pkg.sv
// Shared types and codes for the slider travel sequencer.
// No dependencies; every other file refers to it by scoped names.
package sts_pkg;

	// Item modes
	localparam logic [2:0] MODE_TICK      = 3'd0;
	localparam logic [2:0] MODE_MOVE_UP   = 3'd1;
	localparam logic [2:0] MODE_MOVE_DOWN = 3'd2;
	localparam logic [2:0] MODE_STOP      = 3'd3;
	localparam logic [2:0] MODE_RESET     = 3'd4;
	localparam logic [2:0] MODE_ENABLE    = 3'd5;
	localparam logic [2:0] MODE_DISABLE   = 3'd6;
	localparam logic [2:0] MODE_JAM_CHECK = 3'd7;

	// Travel states
	localparam logic [2:0] ST_IDLE      = 3'd0;
	localparam logic [2:0] ST_UP        = 3'd1;
	localparam logic [2:0] ST_DOWN      = 3'd2;
	localparam logic [2:0] ST_STOP_UP   = 3'd3;
	localparam logic [2:0] ST_STOP_DOWN = 3'd4;
	localparam logic [2:0] ST_ERROR     = 3'd5;

	// Loop selection
	localparam logic [1:0] LOOP_ZERO  = 2'd0;
	localparam logic [1:0] LOOP_SPEED = 2'd1;
	localparam logic [1:0] LOOP_ANGLE = 2'd2;

	// Register indexes on the configuration port
	localparam logic [2:0] REG_LIMIT_LEVEL    = 3'd0;
	localparam logic [2:0] REG_LIMIT_DEBOUNCE = 3'd1;
	localparam logic [2:0] REG_JAM_ERROR      = 3'd2;
	localparam logic [2:0] REG_JAM_TICKS      = 3'd3;
	localparam logic [2:0] REG_HOLD_OFFSET    = 3'd4;

	localparam int unsigned CFG_ADDR_W = 5;

	typedef struct packed {
		logic               limit_active_level;
		logic [15:0]        limit_debounce_ticks;
		logic [15:0]        jam_speed_error;
		logic [15:0]        jam_tick_limit;
		logic signed [15:0] down_hold_offset;
	} cfg_t;

	typedef struct packed {
		logic [2:0]         slider_state;
		logic [1:0]         loop_select;
		logic signed [15:0] speed_setpoint;
		logic signed [31:0] angle_setpoint;
		logic signed [31:0] jam_angle;
		logic               enabled;
	} result_t;

endpackage

FILE: sv/sts_cfg_regs.sv
// Configuration register file of the slider travel sequencer, APB-style port.
// Depends on sts_pkg for register indexes and the cfg_t bundle.
module sts_cfg_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [sts_pkg::CFG_ADDR_W-1:0]     paddr,
	input  logic [31:0]                        pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready,
	output sts_pkg::cfg_t                      cfg
);

	sts_pkg::cfg_t cfg_q;
	logic [2:0]    reg_idx;
	logic          wr_en;

	assign reg_idx = paddr[4:2];
	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.limit_active_level   <= 1'b0;
			cfg_q.limit_debounce_ticks <= 16'd50;
			cfg_q.jam_speed_error      <= 16'd350;
			cfg_q.jam_tick_limit       <= 16'd100;
			cfg_q.down_hold_offset     <= 16'sd100;
		end else if (wr_en) begin
			case (reg_idx)
				sts_pkg::REG_LIMIT_LEVEL:    cfg_q.limit_active_level   <= pwdata[0];
				sts_pkg::REG_LIMIT_DEBOUNCE: cfg_q.limit_debounce_ticks <= pwdata[15:0];
				sts_pkg::REG_JAM_ERROR:      cfg_q.jam_speed_error      <= pwdata[15:0];
				sts_pkg::REG_JAM_TICKS:      cfg_q.jam_tick_limit       <= pwdata[15:0];
				sts_pkg::REG_HOLD_OFFSET:    cfg_q.down_hold_offset     <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			sts_pkg::REG_LIMIT_LEVEL:    prdata = {31'd0, cfg_q.limit_active_level};
			sts_pkg::REG_LIMIT_DEBOUNCE: prdata = {16'd0, cfg_q.limit_debounce_ticks};
			sts_pkg::REG_JAM_ERROR:      prdata = {16'd0, cfg_q.jam_speed_error};
			sts_pkg::REG_JAM_TICKS:      prdata = {16'd0, cfg_q.jam_tick_limit};
			sts_pkg::REG_HOLD_OFFSET:    prdata = {16'd0, cfg_q.down_hold_offset};
			default:                     prdata = 32'd0;
		endcase
	end

endmodule

FILE: sv/sts_core.sv
// Travel state registers and the one-pass update for each accepted item.
// Depends on sts_pkg for codes, cfg_t and result_t.
module sts_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_fire,
	input  logic [2:0]           mode,
	input  logic signed [15:0]   speed_command,
	input  logic                 limit_pin,
	input  logic signed [15:0]   measured_speed,
	input  logic signed [31:0]   total_angle,
	input  sts_pkg::cfg_t        cfg,
	output sts_pkg::result_t     result
);

	localparam logic [15:0] LIMIT_CNT_MAX = 16'hFFFF;
	localparam logic [16:0] JAM_CNT_MAX   = 17'h1FFFF;

	logic [2:0]         state_q, state_d;
	logic               enabled_q, enabled_d;
	logic               angle_mode_q, angle_mode_d;
	logic signed [15:0] speed_q, speed_d;
	logic signed [31:0] angle_q, angle_d;
	logic [15:0]        limit_cnt_q, limit_cnt_d;
	logic [16:0]        jam_cnt_q, jam_cnt_d;
	logic signed [31:0] jam_pos_q, jam_pos_d;

	logic signed [16:0] speed_err;
	logic [16:0]        err_mag;
	logic [16:0]        jam_cnt_step;
	logic               jam_hit;
	logic [15:0]        limit_cnt_step;
	logic               limit_hit;
	logic signed [31:0] hold_offset;

	// Jam test: exact 17-bit error, saturating run count; also the saturating limit debounce count and the hold offset
	always_comb begin
		speed_err    = {speed_q[15], speed_q} - {measured_speed[15], measured_speed};
		err_mag      = speed_err[16] ? 17'(-speed_err) : 17'(speed_err);
		if (err_mag > {1'b0, cfg.jam_speed_error})
			jam_cnt_step = (jam_cnt_q == JAM_CNT_MAX) ? jam_cnt_q : jam_cnt_q + 17'd1;
		else
			jam_cnt_step = 17'd0;
		jam_hit      = jam_cnt_step > {1'b0, cfg.jam_tick_limit};
		limit_cnt_step = (limit_cnt_q == LIMIT_CNT_MAX) ? limit_cnt_q : limit_cnt_q + 16'd1;
		limit_hit    = limit_cnt_step >= cfg.limit_debounce_ticks;
		hold_offset  = {{16{cfg.down_hold_offset[15]}}, cfg.down_hold_offset};
	end

	always_comb begin
		state_d      = state_q;
		enabled_d    = enabled_q;
		angle_mode_d = angle_mode_q;
		speed_d      = speed_q;
		angle_d      = angle_q;
		limit_cnt_d  = limit_cnt_q;
		jam_cnt_d    = jam_cnt_q;
		jam_pos_d    = jam_pos_q;
		case (mode)
			sts_pkg::MODE_TICK: begin
				if (enabled_q && state_q == sts_pkg::ST_UP) begin
					if (limit_pin == cfg.limit_active_level) begin
						if (limit_hit) begin
							limit_cnt_d  = 16'd0;
							angle_d      = total_angle;
							angle_mode_d = 1'b1;
							state_d      = sts_pkg::ST_STOP_UP;
						end else begin
							limit_cnt_d = limit_cnt_step;
						end
					end else begin
						limit_cnt_d = 16'd0;
					end
				end else if (enabled_q && state_q == sts_pkg::ST_DOWN) begin
					jam_cnt_d = jam_hit ? 17'd0 : jam_cnt_step;
					if (jam_hit) begin
						jam_pos_d    = total_angle;
						angle_d      = total_angle + hold_offset;
						angle_mode_d = 1'b1;
						state_d      = sts_pkg::ST_STOP_DOWN;
					end
				end
			end
			sts_pkg::MODE_MOVE_UP, sts_pkg::MODE_MOVE_DOWN: begin
				enabled_d    = 1'b1;
				speed_d      = speed_command;
				angle_mode_d = 1'b0;
				state_d      = (mode == sts_pkg::MODE_MOVE_UP) ? sts_pkg::ST_UP : sts_pkg::ST_DOWN;
			end
			sts_pkg::MODE_STOP: begin
				angle_d      = total_angle;
				angle_mode_d = 1'b1;
			end
			sts_pkg::MODE_RESET: begin
				state_d     = sts_pkg::ST_IDLE;
				speed_d     = 16'sd0;
				jam_cnt_d   = 17'd0;
				limit_cnt_d = 16'd0;
				enabled_d   = 1'b0;
			end
			sts_pkg::MODE_ENABLE: begin
				enabled_d = 1'b1;
			end
			sts_pkg::MODE_DISABLE: begin
				enabled_d = 1'b0;
				state_d   = sts_pkg::ST_IDLE;
			end
			default: begin
				// Stand-alone jam check: not gated by enable, ends in error
				if (state_q == sts_pkg::ST_UP || state_q == sts_pkg::ST_DOWN) begin
					jam_cnt_d = jam_hit ? 17'd0 : jam_cnt_step;
					if (jam_hit) begin
						state_d   = sts_pkg::ST_ERROR;
						jam_pos_d = total_angle;
					end
				end
			end
		endcase
	end

	always_comb begin
		result.slider_state   = state_d;
		result.speed_setpoint = speed_d;
		result.angle_setpoint = angle_d;
		result.jam_angle      = jam_pos_d;
		result.enabled        = enabled_d;
		if (!enabled_d)
			result.loop_select = sts_pkg::LOOP_ZERO;
		else if (state_d == sts_pkg::ST_UP || state_d == sts_pkg::ST_DOWN)
			result.loop_select = sts_pkg::LOOP_SPEED;
		else if (state_d == sts_pkg::ST_STOP_UP || state_d == sts_pkg::ST_STOP_DOWN)
			result.loop_select = sts_pkg::LOOP_ANGLE;
		else
			result.loop_select = sts_pkg::LOOP_ZERO;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= sts_pkg::ST_IDLE;
			enabled_q    <= 1'b0;
			angle_mode_q <= 1'b0;
			speed_q      <= 16'sd0;
			angle_q      <= 32'sd0;
			limit_cnt_q  <= 16'd0;
			jam_cnt_q    <= 17'd0;
			jam_pos_q    <= 32'sd0;
		end else if (item_fire) begin
			state_q      <= state_d;
			enabled_q    <= enabled_d;
			angle_mode_q <= angle_mode_d;
			speed_q      <= speed_d;
			angle_q      <= angle_d;
			limit_cnt_q  <= limit_cnt_d;
			jam_cnt_q    <= jam_cnt_d;
			jam_pos_q    <= jam_pos_d;
		end
	end

endmodule

FILE: sv/sts_out_queue.sv
// Two-entry result register with skid slot for the slider travel sequencer.
// Depends on sts_pkg for result_t.
module sts_out_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  sts_pkg::result_t push_data,
	output logic             full,
	output logic             pop_valid,
	input  logic             pop_stall,
	output sts_pkg::result_t pop_data
);

	sts_pkg::result_t head_q, skid_q;
	logic [1:0]       count_q;
	logic             pop;

	assign pop_valid = (count_q != 2'd0);
	assign full      = (count_q == 2'd2);
	assign pop       = pop_valid & ~pop_stall;
	assign pop_data  = head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else begin
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	// Payload slots carry no reset
	always_ff @(posedge clk) begin
		case ({push, pop})
			2'b10: begin
				if (count_q == 2'd0)
					head_q <= push_data;
				else
					skid_q <= push_data;
			end
			2'b01: begin
				head_q <= skid_q;
			end
			2'b11: begin
				if (count_q == 2'd1) begin
					head_q <= push_data;
				end else begin
					head_q <= skid_q;
					skid_q <= push_data;
				end
			end
			default: ;
		endcase
	end

endmodule

FILE: sv/slider_travel_sequencer_top.sv
// Slider travel sequencer, top level.
// Items are taken one per cycle while the result buffer has room; each result is
// registered there. The state update and setpoint choice are one pass.
// A two-entry result buffer keeps input open for one result while output stalls.
// Reset (arst_n low, asynchronous): state idle, disabled, setpoints zero,
// registers back to their defaults, result buffer empty.
module slider_travel_sequencer_top (
	input  logic                           clk,
	input  logic                           arst_n,

	// Configuration port
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [sts_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready,

	// Item channel
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [2:0]                     mode,
	input  logic signed [15:0]             speed_command,
	input  logic                           limit_pin,
	input  logic signed [15:0]             measured_speed,
	input  logic signed [31:0]             total_angle,

	// Result channel
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [2:0]                     slider_state,
	output logic [1:0]                     loop_select,
	output logic signed [15:0]             speed_setpoint,
	output logic signed [31:0]             angle_setpoint,
	output logic signed [31:0]             jam_angle,
	output logic                           enabled
);

	sts_pkg::cfg_t    cfg;
	sts_pkg::result_t next_result;
	sts_pkg::result_t head_result;
	logic             buf_full;
	logic             in_fire;

	// Hold the item channel only when both result slots are occupied
	assign in_stall = buf_full;
	assign in_fire  = in_valid & ~buf_full;

	sts_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Advance the travel state on every item transfer; the core presents the
	// post-item view as next_result in the same cycle
	sts_core u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_fire      (in_fire),
		.mode           (mode),
		.speed_command  (speed_command),
		.limit_pin      (limit_pin),
		.measured_speed (measured_speed),
		.total_angle    (total_angle),
		.cfg            (cfg),
		.result         (next_result)
	);

	// Register the result; the skid slot absorbs one more while output stalls
	sts_out_queue u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_fire),
		.push_data (next_result),
		.full      (buf_full),
		.pop_valid (out_valid),
		.pop_stall (out_stall),
		.pop_data  (head_result)
	);

	assign slider_state   = head_result.slider_state;
	assign loop_select    = head_result.loop_select;
	assign speed_setpoint = head_result.speed_setpoint;
	assign angle_setpoint = head_result.angle_setpoint;
	assign jam_angle      = head_result.jam_angle;
	assign enabled        = head_result.enabled;

endmodule

FILE: sv/sts_checker.sv
// Port-level checks for the slider travel sequencer, bound to the top level.
// Depends on sts_pkg for state and loop codes.
module sts_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [2:0]  slider_state,
	input logic [1:0]  loop_select,
	input logic        enabled
);

	// Input is held back only while results are pending
	a_stall_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("in_stall high with no result pending");

	// A transfer in always leaves a result pending next cycle
	a_item_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> out_valid)
		else $error("accepted item produced no result");

	// A stalled result stays put
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(slider_state)
			&& $stable(loop_select) && $stable(enabled)))
		else $error("stalled result changed");

	// Disabled slider never drives a loop
	a_disabled_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !enabled) |-> loop_select == sts_pkg::LOOP_ZERO)
		else $error("loop active while disabled");

	// Enabled and moving runs the speed loop
	a_moving_speed: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && enabled && (slider_state == sts_pkg::ST_UP
			|| slider_state == sts_pkg::ST_DOWN)) |-> loop_select == sts_pkg::LOOP_SPEED)
		else $error("moving without speed loop");

endmodule

bind slider_travel_sequencer_top sts_checker u_sts_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.slider_state (slider_state),
	.loop_select  (loop_select),
	.enabled      (enabled)
);
